// File: design/skq_pkg.sv
// Shared types, scancode constants and the set-1 translation tables.
package skq_pkg;

  typedef enum logic [1:0] {
    CMD_SCAN     = 2'd0,
    CMD_POP_CHAR = 2'd1,
    CMD_POP_CODE = 2'd2,
    CMD_FLUSH    = 2'd3
  } skq_cmd_t;

  // queue control for one request
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } skq_qctl_t;

  localparam int unsigned CHAR_W = 7;

  localparam logic [7:0]        REL_BIT     = 8'h80;
  localparam logic [CHAR_W-1:0] CODE_MASK   = 7'h7F;
  localparam logic [CHAR_W-1:0] LSHIFT_CODE = 7'h2A;
  localparam logic [CHAR_W-1:0] RSHIFT_CODE = 7'h36;
  localparam logic [CHAR_W-1:0] CAPS_CODE   = 7'h3A;

  localparam logic [CHAR_W-1:0] PLAIN_TAB [64] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [CHAR_W-1:0] SHIFT_TAB [64] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // make code to US ASCII; 0 means no character
  function automatic logic [CHAR_W-1:0] translate(input logic [CHAR_W-1:0] mc,
                                                  input logic shift,
                                                  input logic caps);
    logic letter;
    logic up;
    letter = (mc inside {[7'h10:7'h19], [7'h1E:7'h26], [7'h2C:7'h32]});
    up     = letter ? (shift | caps) : shift;
    if (mc[6]) begin
      return '0;
    end
    return up ? SHIFT_TAB[mc[5:0]] : PLAIN_TAB[mc[5:0]];
  endfunction

endpackage

// File: design/skq_queue.sv
// Ring queue of 7-bit entries in a synchronous memory with registered read.
module skq_queue import skq_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  skq_qctl_t                    ctl,
  input  logic [CHAR_W-1:0]            push_data,
  output logic                         pop_ok,
  output logic [CHAR_W-1:0]            rd_data,
  output logic [$clog2(DEPTH+1)-1:0]   fill
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rd_data_r;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [LW-1:0]     fill_r, fill_nxt;
  logic              push_ok;

  assign push_ok = ctl.push && (fill_r != LW'(DEPTH));
  assign pop_ok  = ctl.pop && (fill_r != '0);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (ctl.flush) begin
      head_nxt = '0;
      tail_nxt = '0;
      fill_nxt = '0;
    end else if (push_ok) begin
      tail_nxt = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
      fill_nxt = fill_r + 1'b1;
    end else if (pop_ok) begin
      head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  // push and pop never share an edge, so no same-address collision
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail_r] <= push_data;
    end
    if (pop_ok) begin
      rd_data_r <= mem[head_r];
    end
  end

  assign rd_data = rd_data_r;
  assign fill    = fill_r;

endmodule

// File: design/scancode_to_ascii_key_queue.sv
// Top level: set-1 scancode translator feeding a character queue and a make code queue.
// A request passes through stage 1 and the output register; out_valid marks its result.
// Throughput: one request per cycle unless out_ready stalls the output; each queue memory's
//   single read port is used by pops only, and reads land in a register the next cycle.
// Reset (rst_n, synchronous, active low): flags clear, both queues empty, pipeline
//   empty. Queue memories keep their contents; only written entries are read.
module scancode_to_ascii_key_queue import skq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_command,
  input  logic [7:0]                        in_scan_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [CHAR_W-1:0]                 out_popped_value,
  output logic                              out_pop_valid,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]  out_char_level,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]  out_code_level,
  output logic                              out_shift_held,
  output logic                              out_caps_on
);

  localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);

  // Request decode and flag update, all in the accept cycle.
  skq_cmd_t          cmd;
  logic              accept;
  logic              rel;
  logic [CHAR_W-1:0] mc;
  logic [CHAR_W-1:0] ch;
  logic              shift_r, shift_nxt;
  logic              caps_r, caps_nxt;
  skq_qctl_t         char_ctl, code_ctl;
  logic              char_pop_ok, code_pop_ok;
  logic [CHAR_W-1:0] char_rd, code_rd;
  logic [LVL_W-1:0]  char_fill, code_fill;

  // Stage 1 waits for the queue read; output register holds the result.
  logic s1_valid_r, s1_valid_nxt;
  logic s1_pop_ok_r;
  logic s1_code_sel_r;
  logic s1_adv;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_value_r;
  logic              out_pop_valid_r;
  logic [LVL_W-1:0]  out_char_level_r;
  logic [LVL_W-1:0]  out_code_level_r;
  logic              out_shift_r;
  logic              out_caps_r;

  assign cmd    = skq_cmd_t'(in_command);
  assign s1_adv = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept = in_valid && in_ready;

  assign rel = (in_scan_byte & REL_BIT) != 8'h00;
  assign mc  = in_scan_byte[CHAR_W-1:0] & CODE_MASK;

  always_comb begin
    shift_nxt = shift_r;
    caps_nxt  = caps_r;
    char_ctl  = '0;
    code_ctl  = '0;
    ch        = '0;
    if (accept) begin
      case (cmd)
        CMD_SCAN: begin
          if (mc == LSHIFT_CODE || mc == RSHIFT_CODE) begin
            shift_nxt = !rel;
          end else if (mc == CAPS_CODE && !rel) begin
            caps_nxt = !caps_r;
          end
          // translation sees the updated flags
          ch            = translate(mc, shift_nxt, caps_nxt);
          code_ctl.push = !rel;
          char_ctl.push = !rel && (ch != '0);
        end
        CMD_POP_CHAR: char_ctl.pop = 1'b1;
        CMD_POP_CODE: code_ctl.pop = 1'b1;
        CMD_FLUSH: begin
          char_ctl.flush = 1'b1;
          code_ctl.flush = 1'b1;
        end
        default: ;
      endcase
    end
  end

  skq_queue #(.DEPTH(QUEUE_DEPTH)) u_char_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (char_ctl),
    .push_data (ch),
    .pop_ok    (char_pop_ok),
    .rd_data   (char_rd),
    .fill      (char_fill)
  );

  skq_queue #(.DEPTH(QUEUE_DEPTH)) u_code_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (code_ctl),
    .push_data (mc),
    .pop_ok    (code_pop_ok),
    .rd_data   (code_rd),
    .fill      (code_fill)
  );

  assign s1_valid_nxt  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= 1'b0;
      caps_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      shift_r     <= shift_nxt;
      caps_r      <= caps_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload. While stage 1 holds, no new request enters, so queue fills
  // and flags still describe the state right after the stage 1 request.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pop_ok_r   <= char_pop_ok || code_pop_ok;
      s1_code_sel_r <= (cmd == CMD_POP_CODE);
    end
    if (s1_adv) begin
      out_value_r      <= s1_pop_ok_r ? (s1_code_sel_r ? code_rd : char_rd) : '0;
      out_pop_valid_r  <= s1_pop_ok_r;
      out_char_level_r <= char_fill;
      out_code_level_r <= code_fill;
      out_shift_r      <= shift_r;
      out_caps_r       <= caps_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_value_r;
  assign out_pop_valid    = out_pop_valid_r;
  assign out_char_level   = out_char_level_r;
  assign out_code_level   = out_code_level_r;
  assign out_shift_held   = out_shift_r;
  assign out_caps_on      = out_caps_r;

  // Queue fills stay within depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    char_fill <= LVL_W'(QUEUE_DEPTH) && code_fill <= LVL_W'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  // A flush empties both queues.
  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd == CMD_FLUSH |=> char_fill == '0 && code_fill == '0)
    else $error("flush left entries");

  // A pop on an empty character queue reports no entry.
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd == CMD_POP_CHAR && char_fill == '0 |=> !s1_pop_ok_r)
    else $error("pop of empty queue marked valid");

  // Stage 1 cannot be overwritten while it waits.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |-> !accept)
    else $error("stage 1 overrun");

endmodule
